/* design/bmp_pkg.sv */
// Shared types and constants of the binary time message parser.
package bmp_pkg;

  localparam int BYTE_W  = 8;
  localparam int WEEK_W  = 16;
  localparam int TOW_W   = 32;
  localparam int YEAR_W  = 16;
  localparam int SEC_W   = 23;
  localparam int OFS_W   = 4;
  localparam int DT_N    = 5;
  localparam int DT_IDX_W = 3;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;
  localparam logic [BYTE_W-1:0] TYPE_GPS  = 8'h02;
  localparam logic [BYTE_W-1:0] TYPE_UTC  = 8'h03;
  localparam logic [BYTE_W-1:0] TYPE_TAIL = 8'h01;

  localparam logic [OFS_W-1:0] GPS_WEEK_OFS = 4'd4;
  localparam logic [OFS_W-1:0] GPS_TOW_OFS  = 4'd6;
  localparam logic [OFS_W-1:0] GPS_LAST_OFS = 4'd9;
  localparam logic [OFS_W-1:0] UTC_TOW_OFS  = 4'd5;
  localparam logic [OFS_W-1:0] UTC_YEAR_OFS = 4'd9;
  localparam logic [OFS_W-1:0] UTC_DATE_OFS = 4'd11;
  localparam logic [OFS_W-1:0] UTC_LAST_OFS = 4'd15;

  localparam logic [CFG_IDX_W-1:0] REG_WEEK_FLOOR   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEEK_CEILING = 8'd1;

  localparam logic [WEEK_W-1:0] WEEK_FLOOR_RESET   = 16'd1990;
  localparam logic [WEEK_W-1:0] WEEK_CEILING_RESET = 16'd3000;

  // floor(x / 1000) == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
  localparam int MAGIC_W   = 29;
  localparam int DIV_SHIFT = 38;
  localparam int PROD_W    = TOW_W + MAGIC_W;
  localparam logic [MAGIC_W-1:0] DIV_MAGIC = 29'd274877907;

  typedef enum logic {
    KIND_GPS = 1'b0,
    KIND_UTC = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                         kind;
    logic [WEEK_W-1:0]             week;
    logic [TOW_W-1:0]              tow;
    logic [YEAR_W-1:0]             year;
    logic [DT_N-1:0][BYTE_W-1:0]   date_time;
  } record_t;

  typedef struct packed {
    logic [WEEK_W-1:0] floor_week;
    logic [WEEK_W-1:0] ceiling_week;
  } window_t;

endpackage

/* design/bmp_parser.sv */
// Header scanner and payload capture, one byte per accepted item.
module bmp_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [bmp_pkg::BYTE_W-1:0]    data_byte,
  input  logic                          buffer_start,
  output logic                          emit,
  output bmp_pkg::record_t              rec
);

  logic [bmp_pkg::BYTE_W-1:0] older_byte, newer_byte;
  logic                       capturing, capturing_next;
  logic                       capture_is_utc, capture_is_utc_next;
  logic [bmp_pkg::OFS_W-1:0]  capture_offset, capture_offset_next;
  logic                       scan_stopped, scan_stopped_next;
  logic [bmp_pkg::WEEK_W-1:0] held_week, held_week_next;
  logic [bmp_pkg::TOW_W-1:0]  held_tow, held_tow_next;
  logic [bmp_pkg::YEAR_W-1:0] held_year, held_year_next;
  logic [bmp_pkg::DT_N-1:0][bmp_pkg::BYTE_W-1:0] held_date_time, held_date_time_next;

  logic [bmp_pkg::BYTE_W-1:0] older_eff, newer_eff;
  logic [bmp_pkg::OFS_W-1:0]  lane;
  logic                       emit_utc;

  always_comb begin
    older_eff            = buffer_start ? '0 : older_byte;
    newer_eff            = buffer_start ? '0 : newer_byte;
    scan_stopped_next    = buffer_start ? 1'b0 : scan_stopped;
    capturing_next       = capturing;
    capture_is_utc_next  = capture_is_utc;
    capture_offset_next  = capture_offset;
    held_week_next       = held_week;
    held_tow_next        = held_tow;
    held_year_next       = held_year;
    held_date_time_next  = held_date_time;
    lane                 = '0;
    emit                 = 1'b0;
    emit_utc             = 1'b0;
    if (capturing) begin
      capture_offset_next = capture_offset + bmp_pkg::OFS_W'(1);
      if (!capture_is_utc) begin
        if (capture_offset_next >= bmp_pkg::GPS_WEEK_OFS &&
            capture_offset_next < bmp_pkg::GPS_TOW_OFS) begin
          lane = capture_offset_next - bmp_pkg::GPS_WEEK_OFS;
          held_week_next[{lane[0], 3'b000} +: bmp_pkg::BYTE_W] = data_byte;
        end else if (capture_offset_next >= bmp_pkg::GPS_TOW_OFS &&
                     capture_offset_next <= bmp_pkg::GPS_LAST_OFS) begin
          lane = capture_offset_next - bmp_pkg::GPS_TOW_OFS;
          held_tow_next[{lane[1:0], 3'b000} +: bmp_pkg::BYTE_W] = data_byte;
        end
        if (capture_offset_next == bmp_pkg::GPS_LAST_OFS) begin
          emit           = 1'b1;
          capturing_next = 1'b0;
        end
      end else begin
        if (capture_offset_next >= bmp_pkg::UTC_TOW_OFS &&
            capture_offset_next < bmp_pkg::UTC_YEAR_OFS) begin
          lane = capture_offset_next - bmp_pkg::UTC_TOW_OFS;
          held_tow_next[{lane[1:0], 3'b000} +: bmp_pkg::BYTE_W] = data_byte;
        end else if (capture_offset_next >= bmp_pkg::UTC_YEAR_OFS &&
                     capture_offset_next < bmp_pkg::UTC_DATE_OFS) begin
          lane = capture_offset_next - bmp_pkg::UTC_YEAR_OFS;
          held_year_next[{lane[0], 3'b000} +: bmp_pkg::BYTE_W] = data_byte;
        end else if (capture_offset_next >= bmp_pkg::UTC_DATE_OFS) begin
          lane = capture_offset_next - bmp_pkg::UTC_DATE_OFS;
          held_date_time_next[lane[bmp_pkg::DT_IDX_W-1:0]] = data_byte;
        end
        if (capture_offset_next == bmp_pkg::UTC_LAST_OFS) begin
          emit              = 1'b1;
          emit_utc          = 1'b1;
          capturing_next    = 1'b0;
          scan_stopped_next = 1'b1;
        end
      end
    end else if (!scan_stopped_next && data_byte == bmp_pkg::TYPE_TAIL &&
                 older_eff == bmp_pkg::SYNC_BYTE &&
                 (newer_eff == bmp_pkg::TYPE_GPS || newer_eff == bmp_pkg::TYPE_UTC)) begin
      capturing_next      = 1'b1;
      capture_is_utc_next = (newer_eff == bmp_pkg::TYPE_UTC);
      capture_offset_next = '0;
    end

    rec.kind      = emit_utc ? bmp_pkg::KIND_UTC : bmp_pkg::KIND_GPS;
    rec.week      = emit_utc ? '0 : held_week_next;
    rec.tow       = held_tow_next;
    rec.year      = emit_utc ? held_year_next : '0;
    rec.date_time = emit_utc ? held_date_time_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_byte     <= '0;
      newer_byte     <= '0;
      capturing      <= 1'b0;
      capture_is_utc <= 1'b0;
      capture_offset <= '0;
      scan_stopped   <= 1'b0;
    end else if (accept) begin
      older_byte     <= newer_eff;
      newer_byte     <= data_byte;
      capturing      <= capturing_next;
      capture_is_utc <= capture_is_utc_next;
      capture_offset <= capture_offset_next;
      scan_stopped   <= scan_stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_week      <= held_week_next;
      held_tow       <= held_tow_next;
      held_year      <= held_year_next;
      held_date_time <= held_date_time_next;
    end
  end

endmodule

/* design/bmp_scale.sv */
// Two-stage result pipeline: window compare and time-of-week scaling.
module bmp_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        emit,
  input  bmp_pkg::record_t            rec,
  input  bmp_pkg::window_t            window,
  output logic                        ready,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bmp_pkg::record_t            out_rec,
  output logic                        out_in_window,
  output logic [bmp_pkg::SEC_W-1:0]   out_seconds
);

  logic                          s1_valid;
  bmp_pkg::record_t              s1_rec;
  logic                          s2_valid;
  logic [bmp_pkg::PROD_W-1:0]    s2_product;
  logic                          s2_adv, s1_adv;

  assign s2_adv = !s2_valid || !out_stall;
  assign s1_adv = !s1_valid || s2_adv;
  assign ready  = s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_adv) s1_valid <= emit;
      if (s2_adv) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) s1_rec <= rec;
    if (s2_adv) begin
      out_rec       <= s1_rec;
      out_in_window <= (s1_rec.kind == bmp_pkg::KIND_GPS) &&
                       (s1_rec.week > window.floor_week) &&
                       (s1_rec.week < window.ceiling_week);
      s2_product    <= bmp_pkg::PROD_W'(s1_rec.tow) * bmp_pkg::PROD_W'(bmp_pkg::DIV_MAGIC);
    end
  end

  assign out_valid   = s2_valid;
  assign out_seconds = s2_product[bmp_pkg::DIV_SHIFT +: bmp_pkg::SEC_W];

endmodule

/* design/binary_time_message_parser.sv */
// Top level of the binary time message parser.
// Result path: a result is registered in stage s1, then in stage s2, which drives out_valid.
// Throughput: one byte per cycle; in_stall rises only when both result stages are
// full and the output is stalled.
// Reset: synchronous; clears history, capture and scan state, empties the pipeline,
// and sets the week window to 1990..3000.
module binary_time_message_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bmp_pkg::BYTE_W-1:0]      data_byte,
  input  logic                            buffer_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            message_kind,
  output logic [bmp_pkg::WEEK_W-1:0]      week_number,
  output logic                            week_in_window,
  output logic [bmp_pkg::SEC_W-1:0]       tow_seconds,
  output logic [bmp_pkg::YEAR_W-1:0]      utc_year,
  output logic [bmp_pkg::BYTE_W-1:0]      utc_month,
  output logic [bmp_pkg::BYTE_W-1:0]      utc_day,
  output logic [bmp_pkg::BYTE_W-1:0]      utc_hour,
  output logic [bmp_pkg::BYTE_W-1:0]      utc_minute,
  output logic [bmp_pkg::BYTE_W-1:0]      utc_second,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bmp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bmp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bmp_pkg::window_t window;
  bmp_pkg::record_t rec, out_rec;
  logic             emit, ready, in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = !ready;
  assign in_accept = in_valid && ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window.floor_week   <= bmp_pkg::WEEK_FLOOR_RESET;
      window.ceiling_week <= bmp_pkg::WEEK_CEILING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bmp_pkg::REG_WEEK_FLOOR:   window.floor_week   <= cfg_data;
        bmp_pkg::REG_WEEK_CEILING: window.ceiling_week <= cfg_data;
        default: ;
      endcase
    end
  end

  bmp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .data_byte    (data_byte),
    .buffer_start (buffer_start),
    .emit         (emit),
    .rec          (rec)
  );

  bmp_scale u_scale (
    .clk           (clk),
    .rst           (rst),
    .emit          (emit && in_accept),
    .rec           (rec),
    .window        (window),
    .ready         (ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_rec       (out_rec),
    .out_in_window (week_in_window),
    .out_seconds   (tow_seconds)
  );

  assign message_kind = out_rec.kind;
  assign week_number  = out_rec.week;
  assign utc_year     = out_rec.year;
  assign utc_month    = out_rec.date_time[0];
  assign utc_day      = out_rec.date_time[1];
  assign utc_hour     = out_rec.date_time[2];
  assign utc_minute   = out_rec.date_time[3];
  assign utc_second   = out_rec.date_time[4];

endmodule

/* design/bmp_checker.sv */
// Port-level assertions for the binary time message parser, bound to the top level.
module bmp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            message_kind,
  input logic [bmp_pkg::WEEK_W-1:0]      week_number,
  input logic                            week_in_window,
  input logic [bmp_pkg::SEC_W-1:0]       tow_seconds,
  input logic [bmp_pkg::YEAR_W-1:0]      utc_year,
  input logic [bmp_pkg::BYTE_W-1:0]      utc_month,
  input logic [bmp_pkg::BYTE_W-1:0]      utc_day,
  input logic [bmp_pkg::BYTE_W-1:0]      utc_hour,
  input logic [bmp_pkg::BYTE_W-1:0]      utc_minute,
  input logic [bmp_pkg::BYTE_W-1:0]      utc_second
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_utc_no_week: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_kind == bmp_pkg::KIND_UTC |-> week_number == '0 && !week_in_window)
    else $error("week fields set on utc item");

  a_gps_no_date: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_kind == bmp_pkg::KIND_GPS |->
      utc_year == '0 && utc_month == '0 && utc_day == '0 &&
      utc_hour == '0 && utc_minute == '0 && utc_second == '0)
    else $error("date fields set on gps item");

  a_seconds_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tow_seconds <= bmp_pkg::SEC_W'(4294967))
    else $error("time of week out of range");

endmodule

bind binary_time_message_parser bmp_checker u_checker (.*);

/* verif/binary_time_message_parser_tb.sv */
// Testbench for the binary time message parser: byte stream stimulus, self-checking.
`timescale 1ns / 100ps

module binary_time_message_parser_tb;
  import bmp_pkg::*;

  localparam int MS_PER_S = 1000;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_LIMIT = 5000;
  localparam int ITEMS_END = 900;
  localparam int QUIET_TAIL_START = 780;
  localparam int MAX_REPORTS = 40;
  localparam int TIMEOUT_NS = 1_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP = 8'hFF;

  typedef struct {
    kind_t             kind;
    logic [WEEK_W-1:0] week;
    logic              in_window;
    logic [SEC_W-1:0]  tow_s;
    logic [YEAR_W-1:0] year;
    logic [BYTE_W-1:0] month;
    logic [BYTE_W-1:0] day;
    logic [BYTE_W-1:0] hour;
    logic [BYTE_W-1:0] minute;
    logic [BYTE_W-1:0] second;
  } time_fix_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [BYTE_W-1:0]     data_byte;
  logic                  buffer_start;
  logic                  out_valid;
  logic                  out_stall;
  logic                  message_kind;
  logic [WEEK_W-1:0]     week_number;
  logic                  week_in_window;
  logic [SEC_W-1:0]      tow_seconds;
  logic [YEAR_W-1:0]     utc_year;
  logic [BYTE_W-1:0]     utc_month;
  logic [BYTE_W-1:0]     utc_day;
  logic [BYTE_W-1:0]     utc_hour;
  logic [BYTE_W-1:0]     utc_minute;
  logic [BYTE_W-1:0]     utc_second;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  time_fix_t expected_times[$];
  int mismatch_count = 0;
  int items_sent = 0;
  bit idling_on = 1'b1;
  int stray_pct = 0;

  logic [BYTE_W-1:0] hist_older;
  logic [BYTE_W-1:0] hist_newer;
  logic              cap_active;
  logic              cap_utc;
  logic [OFS_W-1:0]  cap_ofs;
  logic [WEEK_W-1:0] held_week_m;
  logic [TOW_W-1:0]  held_tow_m;
  logic [YEAR_W-1:0] held_year_m;
  logic [BYTE_W-1:0] held_dt_m [DT_N];
  logic              scan_halted;
  window_t           window_m;

  binary_time_message_parser u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .buffer_start(buffer_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .message_kind(message_kind),
    .week_number(week_number),
    .week_in_window(week_in_window),
    .tow_seconds(tow_seconds),
    .utc_year(utc_year),
    .utc_month(utc_month),
    .utc_day(utc_day),
    .utc_hour(utc_hour),
    .utc_minute(utc_minute),
    .utc_second(utc_second),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("ERROR at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic void decode_time_byte(input logic [BYTE_W-1:0] b, input logic start);
    logic [OFS_W-1:0] ofs;
    time_fix_t fix;
    if (start) begin
      hist_older = '0;
      hist_newer = '0;
      scan_halted = 1'b0;
    end
    if (cap_active) begin
      ofs = cap_ofs + 4'd1;
      cap_ofs = ofs;
      if (!cap_utc) begin
        if (ofs == GPS_WEEK_OFS) begin
          held_week_m[7:0] = b;
        end else if (ofs == GPS_WEEK_OFS + 1) begin
          held_week_m[15:8] = b;
        end else if (ofs >= GPS_TOW_OFS && ofs <= GPS_LAST_OFS) begin
          held_tow_m[8*(ofs-GPS_TOW_OFS) +: 8] = b;
        end
        if (ofs == GPS_LAST_OFS) begin
          fix.kind = KIND_GPS;
          fix.week = held_week_m;
          fix.in_window = (held_week_m > window_m.floor_week) &&
                          (held_week_m < window_m.ceiling_week);
          fix.tow_s = SEC_W'(held_tow_m / MS_PER_S);
          fix.year = '0;
          fix.month = '0;
          fix.day = '0;
          fix.hour = '0;
          fix.minute = '0;
          fix.second = '0;
          expected_times.push_back(fix);
          cap_active = 1'b0;
        end
      end else begin
        if (ofs >= UTC_TOW_OFS && ofs < UTC_YEAR_OFS) begin
          held_tow_m[8*(ofs-UTC_TOW_OFS) +: 8] = b;
        end else if (ofs == UTC_YEAR_OFS) begin
          held_year_m[7:0] = b;
        end else if (ofs == UTC_YEAR_OFS + 1) begin
          held_year_m[15:8] = b;
        end else if (ofs >= UTC_DATE_OFS && ofs <= UTC_LAST_OFS) begin
          held_dt_m[ofs-UTC_DATE_OFS] = b;
        end
        if (ofs == UTC_LAST_OFS) begin
          fix.kind = KIND_UTC;
          fix.week = '0;
          fix.in_window = 1'b0;
          fix.tow_s = SEC_W'(held_tow_m / MS_PER_S);
          fix.year = held_year_m;
          fix.month = held_dt_m[0];
          fix.day = held_dt_m[1];
          fix.hour = held_dt_m[2];
          fix.minute = held_dt_m[3];
          fix.second = held_dt_m[4];
          expected_times.push_back(fix);
          cap_active = 1'b0;
          scan_halted = 1'b1;
        end
      end
    end else if (!scan_halted && b == TYPE_TAIL && hist_older == SYNC_BYTE &&
                 (hist_newer == TYPE_GPS || hist_newer == TYPE_UTC)) begin
      cap_active = 1'b1;
      cap_utc = (hist_newer == TYPE_UTC);
      cap_ofs = '0;
    end
    hist_older = hist_newer;
    hist_newer = b;
  endfunction

  function automatic logic stray_start();
    return stray_pct != 0 && $urandom_range(0, 99) < stray_pct;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return SYNC_BYTE;
      1: return TYPE_GPS;
      2: return TYPE_UTC;
      3: return TYPE_TAIL;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [WEEK_W-1:0] pick_week();
    case ($urandom_range(0, 7))
      0: return window_m.floor_week;
      1: return window_m.floor_week + 16'd1;
      2: return window_m.ceiling_week - 16'd1;
      3: return window_m.ceiling_week;
      4: return 16'h0000;
      5: return 16'hFFFF;
      default: return WEEK_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [TOW_W-1:0] pick_tow();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'd999;
      3: return 32'd1000;
      4: return 32'd604799999;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    data_byte = b;
    buffer_start = start;
    do @(posedge clk); while (in_stall);
    decode_time_byte(b, start);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_gps_message(input logic [WEEK_W-1:0] week, input logic [TOW_W-1:0] tow,
                                  input logic first_start);
    send_byte(SYNC_BYTE, first_start);
    send_byte(TYPE_GPS, stray_start());
    send_byte(TYPE_TAIL, stray_start());
    for (int i = 1; i < GPS_WEEK_OFS; i++) send_byte(pick_byte(), stray_start());
    send_byte(week[7:0], stray_start());
    send_byte(week[15:8], stray_start());
    for (int i = 0; i < 4; i++) send_byte(tow[8*i +: 8], stray_start());
  endtask

  task automatic send_utc_message(input logic [TOW_W-1:0] tow, input logic [YEAR_W-1:0] year,
                                  input logic [DT_N-1:0][BYTE_W-1:0] dt,
                                  input logic first_start);
    send_byte(SYNC_BYTE, first_start);
    send_byte(TYPE_UTC, stray_start());
    send_byte(TYPE_TAIL, stray_start());
    for (int i = 1; i < UTC_TOW_OFS; i++) send_byte(pick_byte(), stray_start());
    for (int i = 0; i < 4; i++) send_byte(tow[8*i +: 8], stray_start());
    send_byte(year[7:0], stray_start());
    send_byte(year[15:8], stray_start());
    for (int i = 0; i < DT_N; i++) send_byte(dt[i], stray_start());
  endtask

  task automatic send_random_utc(input logic first_start);
    logic [DT_N-1:0][BYTE_W-1:0] dt;
    dt = (DT_N*BYTE_W)'({$urandom(), $urandom()});
    send_utc_message(pick_tow(), YEAR_W'($urandom_range(0, 65535)), dt, first_start);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_times.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WEEK_FLOOR: window_m.floor_week = value;
      REG_WEEK_CEILING: window_m.ceiling_week = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_window(input logic [WEEK_W-1:0] floor_wk, input logic [WEEK_W-1:0] ceil_wk);
    wait_idle();
    write_register(REG_WEEK_FLOOR, floor_wk);
    write_register(REG_WEEK_CEILING, ceil_wk);
  endtask

  task automatic run_window_phase();
    for (int k = 0; k < 3; k++) send_gps_message(pick_week(), pick_tow(), 1'b1);
    send_random_utc(1'b1);
  endtask

  task automatic test_header_cases();
    send_utc_message(32'hFFFF_FFFF, 16'hFFFF, {DT_N{8'hFF}}, 1'b1);
    // hold off: scan stays stopped for the rest of this buffer
    send_byte(SYNC_BYTE, 1'b0);
    send_byte(TYPE_GPS, 1'b0);
    send_byte(TYPE_TAIL, 1'b0);
    // drop history on the buffer start that lands on the header tail
    send_byte(SYNC_BYTE, 1'b0);
    send_byte(TYPE_UTC, 1'b0);
    send_byte(TYPE_TAIL, 1'b1);
  endtask

  task automatic test_week_window();
    run_window_phase();
    set_window(16'h0000, 16'hFFFF);
    run_window_phase();
    set_window(16'hFFFF, 16'h0000);
    run_window_phase();
    set_window(16'd1000, 16'd1002);
    run_window_phase();
    set_window(16'd1000, 16'd1001);
    run_window_phase();
    set_window(16'hFFFE, 16'hFFFF);
    run_window_phase();
  endtask

  task automatic test_ignored_registers();
    wait_idle();
    write_register(REG_SPARE, 16'h0000);
    write_register(REG_INDEX_TOP, 16'hFFFF);
    run_window_phase();
  endtask

  task automatic test_random_stream();
    int n;
    set_window(16'd2000, 16'd2300);
    stray_pct = 3;
    while (items_sent < ITEMS_END) begin
      if (items_sent >= QUIET_TAIL_START) idling_on = 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_gps_message(pick_week(), pick_tow(), $urandom_range(0, 3) != 0);
        4, 5, 6: send_random_utc($urandom_range(0, 3) != 0);
        7: begin
          n = $urandom_range(1, 8);
          repeat (n) send_byte(pick_byte(), stray_start());
        end
        8: begin
          case ($urandom_range(0, 2))
            0: begin
              send_byte(SYNC_BYTE, stray_start());
              send_byte(TYPE_GPS, stray_start());
              send_byte(TYPE_TAIL, 1'b1);
            end
            1: begin
              send_byte(SYNC_BYTE, stray_start());
              send_byte(BYTE_W'($urandom_range(4, 255)), stray_start());
              send_byte(TYPE_TAIL, stray_start());
            end
            default: begin
              send_byte(SYNC_BYTE, stray_start());
              send_byte($urandom_range(0, 1) ? TYPE_GPS : TYPE_UTC, stray_start());
              send_byte(TYPE_TAIL, stray_start());
              send_byte(pick_byte(), stray_start());
            end
          endcase
        end
        default: send_byte(pick_byte(), 1'b1);
      endcase
    end
    stray_pct = 0;
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    time_fix_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_times.size() == 0) begin
        report_mismatch("result with none pending", message_kind, 0);
      end else begin
        want = expected_times.pop_front();
        if (message_kind !== want.kind) report_mismatch("message_kind", message_kind, want.kind);
        if (week_number !== want.week) report_mismatch("week_number", week_number, want.week);
        if (week_in_window !== want.in_window)
          report_mismatch("week_in_window", week_in_window, want.in_window);
        if (tow_seconds !== want.tow_s) report_mismatch("tow_seconds", tow_seconds, want.tow_s);
        if (utc_year !== want.year) report_mismatch("utc_year", utc_year, want.year);
        if (utc_month !== want.month) report_mismatch("utc_month", utc_month, want.month);
        if (utc_day !== want.day) report_mismatch("utc_day", utc_day, want.day);
        if (utc_hour !== want.hour) report_mismatch("utc_hour", utc_hour, want.hour);
        if (utc_minute !== want.minute) report_mismatch("utc_minute", utc_minute, want.minute);
        if (utc_second !== want.second) report_mismatch("utc_second", utc_second, want.second);
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    buffer_start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hist_older = '0;
    hist_newer = '0;
    cap_active = 1'b0;
    cap_utc = 1'b0;
    cap_ofs = '0;
    held_week_m = '0;
    held_tow_m = '0;
    held_year_m = '0;
    for (int i = 0; i < DT_N; i++) held_dt_m[i] = '0;
    scan_halted = 1'b0;
    window_m.floor_week = WEEK_FLOOR_RESET;
    window_m.ceiling_week = WEEK_CEILING_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_header_cases();
    test_week_window();
    test_ignored_registers();
    test_random_stream();

    in_valid = 1'b0;
    for (int c = 0; c < DRAIN_LIMIT && expected_times.size() != 0; c++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_times.size() != 0)
      report_mismatch("results never delivered", expected_times.size(), 0);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* binary_time_message_parser.f */
design/bmp_pkg.sv
design/bmp_parser.sv
design/bmp_scale.sv
design/binary_time_message_parser.sv
design/bmp_checker.sv
verif/binary_time_message_parser_tb.sv
